// ===== hw/rtl/spq_pkg.sv =====
// Package: shared types and constants of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int PAYLOAD_BITS = 32;
  localparam int LEVEL_BITS   = 8;
  localparam int REQ_BITS     = 2;
  localparam int STATUS_BITS  = 2;
  localparam int COUNT_BITS   = 8;

  localparam int IN_DATA_BITS  = PAYLOAD_BITS + LEVEL_BITS;
  localparam int OUT_DATA_BITS = PAYLOAD_BITS + LEVEL_BITS + COUNT_BITS;

  localparam logic [REQ_BITS-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_PEEK   = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] payload;
    logic [LEVEL_BITS-1:0]   level;
  } spq_entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic       ins;
    logic       rem;
    spq_entry_t ent;
  } spq_cmd_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One storage cell of the sorted chain: holds an entry, shifts left or right.
`timescale 1ns / 1ps
module spq_cell (
  input  logic               clk,
  input  spq_pkg::spq_cmd_t  cmd,
  input  logic               live,
  input  logic               left_stay,
  input  spq_pkg::spq_entry_t left_ent,
  input  spq_pkg::spq_entry_t right_ent,
  output spq_pkg::spq_entry_t ent,
  output logic               stay
);
  import spq_pkg::*;

  spq_entry_t ent_r;
  spq_entry_t ent_nxt;

  // entry keeps its slot on insert: live and not above the new level
  assign stay = live && (ent_r.level <= cmd.ent.level);
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins) begin
      if (!stay) begin
        ent_nxt = left_stay ? cmd.ent : left_ent;
      end
    end else if (cmd.rem) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== hw/rtl/sorted_priority_queue_unit.sv =====
// Top level: sorted priority queue built from a chain of storage cells.
//
// Requests arrive on the in_ stream: in_tuser carries the request kind
// (insert, remove head, peek head), in_tdata the payload tag and level.
// Every request yields exactly one result item on the out_ stream: out_tuser
// carries the status (ok, full, empty), out_tdata the head payload and level
// for a successful remove or peek (zero otherwise) and the entry count after
// the request.
// Each cell compares its level with the broadcast request and either holds,
// loads the new entry or takes its neighbour's entry, all in the same cycle,
// so the time an insert or remove takes does not depend on the occupancy.
// The result is registered and appears in the cycle after acceptance. Throughput:
// one item per cycle while out_tready stays high.
// A stalled receiver holds the result register; in_tready stays high while the
// result register is empty or being drained in the same cycle.
// Reset empties the queue at once (count to zero); entry contents are not
// cleared, only the first count cells are ever read.
`timescale 1ns / 1ps
module sorted_priority_queue_unit #(
  parameter int DEPTH = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] payload_in, [39:32] level_in
  input  logic [spq_pkg::IN_DATA_BITS-1:0]   in_tdata,
  // [1:0] req_type
  input  logic [spq_pkg::REQ_BITS-1:0]       in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] payload_out, [39:32] level_out, [47:40] entry_count
  output logic [spq_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  // [1:0] status
  output logic [spq_pkg::STATUS_BITS-1:0]    out_tuser
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [STATUS_BITS-1:0]   status_r;
  logic [STATUS_BITS-1:0]   status_nxt;
  logic [OUT_DATA_BITS-1:0] data_r;
  logic [OUT_DATA_BITS-1:0] data_nxt;

  logic       acc;
  logic       full;
  logic       empty;
  spq_cmd_t   cmd;
  spq_entry_t new_ent;
  spq_entry_t head;

  spq_entry_t ents  [DEPTH];
  logic       stays [DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign empty     = (cnt_r == '0);

  assign new_ent.payload = in_tdata[PAYLOAD_BITS-1:0];
  assign new_ent.level   = in_tdata[IN_DATA_BITS-1:PAYLOAD_BITS];
  assign head            = ents[0];

  assign cmd.ent = new_ent;
  assign cmd.ins = acc && (in_tuser == REQ_INSERT) && !full;
  assign cmd.rem = acc && (in_tuser == REQ_REMOVE) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t left_ent;
    spq_entry_t right_ent;
    logic       left_stay;

    if (i == 0) begin : g_first
      assign left_ent  = new_ent;
      assign left_stay = 1'b1;
    end else begin : g_mid
      assign left_ent  = ents[i-1];
      assign left_stay = stays[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent = ents[i];
    end else begin : g_body
      assign right_ent = ents[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .live      (CNT_W'(i) < cnt_r),
      .left_stay (left_stay),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent       (ents[i]),
      .stay      (stays[i])
    );
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.ins) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.rem) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_comb begin
    status_nxt    = status_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (acc) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      data_nxt      = '0;
      unique case (in_tuser)
        REQ_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end
        end
        REQ_REMOVE, REQ_PEEK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            data_nxt[PAYLOAD_BITS-1:0]            = head.payload;
            data_nxt[IN_DATA_BITS-1:PAYLOAD_BITS] = head.level;
          end
        end
        default: begin
        end
      endcase
      data_nxt[OUT_DATA_BITS-1:IN_DATA_BITS] = COUNT_BITS'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    data_r   <= data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("insert did not grow the count");

  a_peek_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tuser == REQ_PEEK) |=> cnt_r == $past(cnt_r))
    else $error("peek changed the count");

  a_rem_head: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem |=> (out_tuser == ST_OK) &&
      (out_tdata[IN_DATA_BITS-1:PAYLOAD_BITS] == $past(head.level)))
    else $error("remove returned wrong head");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tuser == REQ_INSERT && full) |=> out_tuser == ST_FULL)
    else $error("insert into full queue not flagged");

endmodule
